/* sv/mlrq_pkg.sv */
package mlrq_pkg;

	localparam int TASK_COUNT  = 32;
	localparam int QUEUE_COUNT = 5;

	localparam int TASK_W  = $clog2(TASK_COUNT);
	localparam int LINK_W  = $clog2(TASK_COUNT + 1);
	localparam int QUEUE_W = $clog2(QUEUE_COUNT);

	localparam int CMD_W  = 2;
	localparam int PRIO_W = 8;
	localparam int QIDX_W = 3;

	localparam logic [LINK_W-1:0] LINK_NONE  = LINK_W'(TASK_COUNT);
	localparam logic [PRIO_W-1:0] PRIO_LOW   = 8'h80;
	localparam logic [PRIO_W-1:0] PRIO_HIGH  = 8'h83;
	localparam logic [PRIO_W-1:0] NULL_QUEUE = 8'd4;

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND  = 2'd0,
		CMD_PREPEND = 2'd1,
		CMD_POP     = 2'd2,
		CMD_REMOVE  = 2'd3
	} cmd_t;

	function automatic logic link_valid(input logic [LINK_W-1:0] l);
		return l < LINK_NONE;
	endfunction

endpackage

/* sv/multilevel_ready_queue_top.sv */
// Insert: S_EXEC, S_WR2 if the queue was non-empty, S_RESP. Pop: S_EXEC, S_POP_RD
// unless the last task leaves, S_RESP. Remove by name: S_EXEC, a walk in S_WALK and
// S_WALK_RD (k <= TASK_COUNT links), S_RM_RD and S_RM_CLR if found, S_RESP; an empty
// queue goes straight to S_RESP. One item at a time; each walk step reads a next link.
// A new item is accepted once the previous result sits in the output register.
// Reset (arst_n low, asynchronous) empties all queues; link memories are not cleared.
module multilevel_ready_queue_top
	import mlrq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  logic [CMD_W-1:0]  cmd,
	input  logic [PRIO_W-1:0] priority_req,
	input  logic [QIDX_W-1:0] queue_index,
	input  logic [TASK_W-1:0] task_id,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output logic [TASK_W-1:0] removed_task,
	output logic              ok
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_WR2,
		S_POP_RD,
		S_WALK,
		S_WALK_RD,
		S_RM_RD,
		S_RM_CLR,
		S_RESP
	} state_t;

	state_t state_q;

	logic [TASK_W-1:0]      head_q [QUEUE_COUNT];
	logic [TASK_W-1:0]      tail_q [QUEUE_COUNT];
	logic [QUEUE_COUNT-1:0] nonempty_q;

	cmd_t               cmd_q;
	logic [QUEUE_W-1:0] q_q;
	logic               req_ok_q;
	logic [TASK_W-1:0]  tid_q;
	logic [LINK_W-1:0]  cur_q;
	logic [LINK_W-1:0]  step_q;
	logic [TASK_W-1:0]  res_task_q;
	logic               res_ok_q;
	logic               rsp_valid_q;
	logic [TASK_W-1:0]  rsp_task_q;
	logic               rsp_ok_q;

	// link memories
	logic [LINK_W-1:0] next_mem [TASK_COUNT];
	logic [LINK_W-1:0] prev_mem [TASK_COUNT];
	logic [LINK_W-1:0] next_rd_q;
	logic [LINK_W-1:0] prev_rd_q;
	logic              next_we;
	logic              prev_we;
	logic [TASK_W-1:0] next_wa;
	logic [TASK_W-1:0] prev_wa;
	logic [LINK_W-1:0] next_wd;
	logic [LINK_W-1:0] prev_wd;
	logic [TASK_W-1:0] next_ra;
	logic [TASK_W-1:0] prev_ra;

	logic              accept;
	logic [PRIO_W-1:0] mapped;
	logic              ne_sel;
	logic [TASK_W-1:0] head_sel;
	logic [TASK_W-1:0] tail_sel;
	logic [LINK_W-1:0] tid_link;

	assign req_stall    = (state_q != S_IDLE);
	assign accept       = req_valid && !req_stall;
	assign rsp_valid    = rsp_valid_q;
	assign removed_task = rsp_task_q;
	assign ok           = rsp_ok_q;

	assign mapped = (priority_req >= PRIO_LOW && priority_req <= PRIO_HIGH)
		? (priority_req - PRIO_LOW) : NULL_QUEUE;

	assign ne_sel   = nonempty_q[q_q];
	assign head_sel = head_q[q_q];
	assign tail_sel = tail_q[q_q];
	assign tid_link = LINK_W'(tid_q);

	always_ff @(posedge clk) begin
		if (next_we) begin
			next_mem[next_wa] <= next_wd;
		end
		if (prev_we) begin
			prev_mem[prev_wa] <= prev_wd;
		end
		next_rd_q <= next_mem[next_ra];
		prev_rd_q <= prev_mem[prev_ra];
	end

	always_comb begin
		next_we = 1'b0;
		prev_we = 1'b0;
		next_wa = tid_q;
		prev_wa = tid_q;
		next_wd = LINK_NONE;
		prev_wd = LINK_NONE;
		next_ra = cur_q[TASK_W-1:0];
		prev_ra = tid_q;
		unique case (state_q)
			S_EXEC: begin
				if (req_ok_q) begin
					unique case (cmd_q)
						CMD_APPEND: begin
							next_we = 1'b1;
							prev_we = 1'b1;
							if (ne_sel) begin
								// link old tail to new task
								next_wa = tail_sel;
								next_wd = tid_link;
								prev_wd = LINK_W'(tail_sel);
							end
						end
						CMD_PREPEND: begin
							next_we = 1'b1;
							prev_we = 1'b1;
							if (ne_sel) begin
								prev_wa = head_sel;
								prev_wd = tid_link;
								next_wd = LINK_W'(head_sel);
							end
						end
						CMD_POP: begin
							next_ra = head_sel;
						end
						CMD_REMOVE: begin
						end
					endcase
				end
			end
			S_WR2: begin
				if (cmd_q == CMD_APPEND) begin
					next_we = 1'b1;
				end else begin
					prev_we = 1'b1;
				end
			end
			S_POP_RD: begin
				next_we = 1'b1;
				next_wa = cur_q[TASK_W-1:0];
				if (link_valid(next_rd_q)) begin
					prev_we = 1'b1;
					prev_wa = next_rd_q[TASK_W-1:0];
				end
			end
			S_RM_RD: begin
				// splice the neighbors together
				if (link_valid(prev_rd_q)) begin
					next_we = 1'b1;
					next_wa = prev_rd_q[TASK_W-1:0];
					next_wd = next_rd_q;
				end
				if (link_valid(next_rd_q)) begin
					prev_we = 1'b1;
					prev_wa = next_rd_q[TASK_W-1:0];
					prev_wd = prev_rd_q;
				end
			end
			S_RM_CLR: begin
				next_we = 1'b1;
				prev_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			nonempty_q  <= '0;
			for (int i = 0; i < QUEUE_COUNT; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
			cmd_q       <= CMD_APPEND;
			q_q         <= '0;
			req_ok_q    <= 1'b0;
			tid_q       <= '0;
			cur_q       <= '0;
			step_q      <= '0;
			res_task_q  <= '0;
			res_ok_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_task_q  <= '0;
			rsp_ok_q    <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q <= cmd_t'(cmd);
						tid_q <= task_id;
						if (cmd_t'(cmd) == CMD_POP) begin
							q_q      <= QUEUE_W'(queue_index);
							req_ok_q <= (32'(queue_index) < 32'(QUEUE_COUNT));
						end else begin
							q_q      <= QUEUE_W'(mapped);
							req_ok_q <= (32'(mapped) < 32'(QUEUE_COUNT));
						end
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					res_task_q <= '0;
					res_ok_q   <= 1'b0;
					state_q    <= S_RESP;
					if (req_ok_q) begin
						unique case (cmd_q)
							CMD_APPEND: begin
								res_ok_q     <= 1'b1;
								tail_q[q_q]  <= tid_q;
								if (ne_sel) begin
									state_q <= S_WR2;
								end else begin
									head_q[q_q]     <= tid_q;
									nonempty_q[q_q] <= 1'b1;
								end
							end
							CMD_PREPEND: begin
								res_ok_q    <= 1'b1;
								head_q[q_q] <= tid_q;
								if (ne_sel) begin
									state_q <= S_WR2;
								end else begin
									tail_q[q_q]     <= tid_q;
									nonempty_q[q_q] <= 1'b1;
								end
							end
							CMD_POP: begin
								if (ne_sel) begin
									res_ok_q   <= 1'b1;
									res_task_q <= head_sel;
									cur_q      <= LINK_W'(head_sel);
									if (head_sel == tail_sel) begin
										nonempty_q[q_q] <= 1'b0;
									end else begin
										state_q <= S_POP_RD;
									end
								end
							end
							CMD_REMOVE: begin
								if (ne_sel) begin
									cur_q   <= LINK_W'(head_sel);
									step_q  <= '0;
									state_q <= S_WALK;
								end
							end
						endcase
					end
				end
				S_WR2: begin
					state_q <= S_RESP;
				end
				S_POP_RD: begin
					if (link_valid(next_rd_q)) begin
						head_q[q_q] <= next_rd_q[TASK_W-1:0];
					end else begin
						nonempty_q[q_q] <= 1'b0;
					end
					state_q <= S_RESP;
				end
				S_WALK: begin
					priority if (step_q == LINK_NONE || !link_valid(cur_q)) begin
						state_q <= S_RESP;
					end else if (cur_q == tid_link) begin
						state_q <= S_RM_RD;
					end else begin
						step_q  <= step_q + 1'b1;
						state_q <= S_WALK_RD;
					end
				end
				S_WALK_RD: begin
					cur_q   <= next_rd_q;
					state_q <= S_WALK;
				end
				S_RM_RD: begin
					if (tid_q == head_sel) begin
						if (link_valid(next_rd_q)) begin
							head_q[q_q] <= next_rd_q[TASK_W-1:0];
						end else begin
							nonempty_q[q_q] <= 1'b0;
						end
					end
					if (tid_q == tail_sel) begin
						if (link_valid(prev_rd_q)) begin
							tail_q[q_q] <= prev_rd_q[TASK_W-1:0];
						end else begin
							nonempty_q[q_q] <= 1'b0;
						end
					end
					state_q <= S_RM_CLR;
				end
				S_RM_CLR: begin
					res_ok_q   <= 1'b1;
					res_task_q <= tid_q;
					state_q    <= S_RESP;
				end
				S_RESP: begin
					// hold until the output register is free
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_valid_q <= 1'b1;
						rsp_task_q  <= res_task_q;
						rsp_ok_q    <= res_ok_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
